[rtl/b32e_pkg.sv]
// b32e_pkg: shared types and the symbol lookup for the base32 encoder
`default_nettype none
package b32e_pkg;

   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned CharWidth   = 7;
   localparam int unsigned GroupWidth  = 5;
   localparam int unsigned PendWidth   = 4;
   localparam int unsigned PendCntW    = 3;
   localparam int unsigned MaxSymbols  = 3;
   localparam int unsigned SymCntW     = 2;
   localparam int unsigned NumLetters  = 26;

   typedef struct packed {
      logic [CharWidth-1:0] symbol_char;
      logic                 last_symbol;
   } sym_type;

   // everything one byte turns into, plus the carry left for the next byte
   typedef struct packed {
      logic [SymCntW-1:0]   count;
      sym_type [MaxSymbols-1:0] syms;
      logic [PendWidth-1:0] next_bits;
      logic [PendCntW-1:0]  next_count;
   } slice_type;

   // 5-bit group to ascii: A-Z then 2-7
   function automatic logic [CharWidth-1:0] group_to_char(input logic [GroupWidth-1:0] g);
      logic [CharWidth-1:0] c;
      if (g < GroupWidth'(NumLetters)) begin
         c = CharWidth'(8'h41) + CharWidth'(g);
      end else begin
         c = CharWidth'(8'h32) + CharWidth'(g - GroupWidth'(NumLetters));
      end
      return c;
   endfunction

endpackage
`default_nettype wire

[rtl/b32e_slicer.sv]
// b32e_slicer: cuts one byte plus pending bits into base32 symbols
`default_nettype none
module b32e_slicer (
   input  wire logic [b32e_pkg::ByteWidth-1:0] data_byte,
   input  wire logic                           end_of_message,
   input  wire logic [b32e_pkg::PendWidth-1:0] pend_bits,
   input  wire logic [b32e_pkg::PendCntW-1:0]  pend_count,
   output b32e_pkg::slice_type                 slice
);
   import b32e_pkg::*;

   localparam int unsigned WordW = ByteWidth + PendWidth;

   logic [WordW-1:0]      word;
   logic [WordW-1:0]      aligned;
   logic [PendCntW-1:0]   cnt;
   logic                  two_groups;
   logic [PendCntW-1:0]   rem;
   logic [PendWidth-1:0]  rem_mask;
   logic [GroupWidth-1:0] g0;
   logic [GroupWidth-1:0] g1;
   logic [GroupWidth-1:0] fill;

   always_comb begin
      cnt  = (pend_count > PendCntW'(PendWidth)) ? PendCntW'(PendWidth) : pend_count;
      word = {pend_bits, data_byte};
      // left-align the live bits so the first group always sits on top
      aligned = word << (PendCntW'(PendWidth) - cnt);
      g0 = aligned[WordW-1 -: GroupWidth];
      g1 = aligned[WordW-1-GroupWidth -: GroupWidth];
      two_groups = (cnt >= PendCntW'(2));
      // bits left after the full groups
      rem = two_groups ? PendCntW'(cnt - PendCntW'(2)) : PendCntW'(cnt + PendCntW'(3));
      rem_mask = PendWidth'((5'd1 << rem) - 5'd1);
      fill = two_groups ? {aligned[1:0], 3'b000} : g1;

      slice = '0;
      slice.syms[0].symbol_char = group_to_char(g0);
      slice.syms[1].symbol_char = group_to_char(two_groups ? g1 : fill);
      slice.syms[2].symbol_char = group_to_char(fill);
      if (!end_of_message) begin
         slice.count      = two_groups ? SymCntW'(2) : SymCntW'(1);
         slice.next_bits  = word[PendWidth-1:0] & rem_mask;
         slice.next_count = rem;
      end else if (two_groups) begin
         if (rem != '0) begin
            slice.count = SymCntW'(3);
            slice.syms[2].last_symbol = 1'b1;
         end else begin
            slice.count = SymCntW'(2);
            slice.syms[1].last_symbol = 1'b1;
         end
      end else begin
         // one full group always leaves three or four bits to fill
         slice.count = SymCntW'(2);
         slice.syms[1].last_symbol = 1'b1;
      end
   end

endmodule
`default_nettype wire

[rtl/base32_encoder.sv]
// base32_encoder: streaming unpadded base32 encoder top level
`default_nettype none
// Takes one message byte per transaction on req_ and gives base32 symbols as
// ascii characters (A-Z, 2-7, no padding) one per transaction on rsp_. A byte
// with req_tlast set closes the message: leftover bits are zero-filled into a
// final symbol and rsp_tlast marks the last symbol of the message. A byte
// makes one to three symbols, about 1.6 on average over a long message, and
// the single result channel moving one symbol per cycle, while rsp_tready does
// not hold it back, sets the rate. A byte is sliced in the cycle it
// is accepted into a small symbol stage; the next byte is taken in the cycle
// the stage hands its last symbol to the output register.
module base32_encoder (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] data_byte
   input  wire logic       req_tlast,   // end_of_message
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [6:0] symbol_char, [7] zero
   output logic            rsp_tlast    // last_symbol
);
   import b32e_pkg::*;

   slice_type                slice;
   logic [PendWidth-1:0]     pend_bits_ff, pend_bits_in;
   logic [PendCntW-1:0]      pend_count_ff, pend_count_in;
   sym_type [MaxSymbols-1:0] stage_ff, stage_in;
   logic [SymCntW-1:0]       stage_cnt_ff, stage_cnt_in;
   sym_type                  out_ff, out_in;
   logic                     out_valid_ff, out_valid_in;
   logic                     accept;
   logic                     move;

   b32e_slicer u_slicer (
      .data_byte      (req_tdata),
      .end_of_message (req_tlast),
      .pend_bits      (pend_bits_ff),
      .pend_count     (pend_count_ff),
      .slice          (slice)
   );

   always_comb begin
      move       = (stage_cnt_ff != '0) && (!out_valid_ff || rsp_tready);
      req_tready = (stage_cnt_ff == '0) || ((stage_cnt_ff == SymCntW'(1)) && move);
      accept     = req_tvalid && req_tready;

      pend_bits_in  = pend_bits_ff;
      pend_count_in = pend_count_ff;
      stage_in      = stage_ff;
      stage_cnt_in  = stage_cnt_ff;
      out_in        = out_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;

      if (move) begin
         out_in       = stage_ff[0];
         out_valid_in = 1'b1;
         stage_in[0]  = stage_ff[1];
         stage_in[1]  = stage_ff[2];
         stage_cnt_in = stage_cnt_ff - SymCntW'(1);
      end
      if (accept) begin
         stage_in      = slice.syms;
         stage_cnt_in  = slice.count;
         pend_bits_in  = slice.next_bits;
         pend_count_in = slice.next_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_bits_ff  <= '0;
         pend_count_ff <= '0;
         stage_cnt_ff  <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         pend_bits_ff  <= pend_bits_in;
         pend_count_ff <= pend_count_in;
         stage_cnt_ff  <= stage_cnt_in;
         out_valid_ff  <= out_valid_in;
      end
      stage_ff <= stage_in;
      out_ff   <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_ff.symbol_char};
   assign rsp_tlast  = out_ff.last_symbol;

endmodule
`default_nettype wire

[bench/base32_encoder_tb.sv]
// base32_encoder_tb: self-checking bench for the streaming base32 encoder
`default_nettype none
module base32_encoder_tb;

   logic       clock;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = '0;   // [7:0] data_byte
   logic       req_tlast  = 1'b0; // end_of_message
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;         // [6:0] symbol_char, [7] zero
   logic       rsp_tlast;         // last_symbol

   localparam string Alphabet  = "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567";
   localparam int    TailWait  = 10;
   localparam int    RandBytes = 150;

   // symbols still owed by the encoder, oldest first
   b32e_pkg::sym_type expected_symbols[$];

   // pending bits not yet forming a full group, kept zero above pend_count
   logic [3:0] pend_bits  = '0;
   logic [2:0] pend_count = '0;

   int  error_count   = 0;
   int  bytes_sent    = 0;
   int  messages_sent = 0;
   int  symbols_seen  = 0;
   int  rsp_stall     = 0;
   bit  no_idle       = 1'b0;

   base32_encoder i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // mostly back to back or short, now and then a long pause
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 50) begin
         return 0;
      end else if (r < 88) begin
         return $urandom_range(1, 3);
      end else begin
         return $urandom_range(6, 24);
      end
   endfunction

   function automatic b32e_pkg::sym_type make_symbol(input logic [4:0] grp, input logic fin);
      b32e_pkg::sym_type s;
      s.symbol_char = 7'(Alphabet[int'(grp)]);
      s.last_symbol = fin;
      return s;
   endfunction

   // expected symbols for one accepted byte, most significant group first
   function automatic void encode_byte(input logic [7:0] value, input logic eom);
      logic [11:0] acc;
      int          cnt;
      acc = {pend_bits, value};
      cnt = int'(pend_count) + 8;
      while (cnt >= 5) begin
         cnt -= 5;
         expected_symbols.push_back(make_symbol(5'(acc >> cnt), 1'b0));
      end
      acc = acc & ((12'd1 << cnt) - 12'd1);
      if (eom) begin
         if (cnt > 0) begin
            // zero-fill the leftover bits on the right into a closing symbol
            expected_symbols.push_back(make_symbol(5'(acc << (5 - cnt)), 1'b1));
         end else begin
            expected_symbols[expected_symbols.size() - 1].last_symbol = 1'b1;
         end
         pend_bits  = '0;
         pend_count = '0;
      end else begin
         pend_bits  = acc[3:0];
         pend_count = 3'(cnt);
      end
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch on symbol %0d: %s got 0x%0h expected 0x%0h",
               symbols_seen, what, got, want);
      error_count++;
   endtask

   task automatic send_byte(input logic [7:0] value, input logic eom);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tlast  <= eom;
      do @(posedge clock); while (!req_tready);
      encode_byte(value, eom);
      bytes_sent++;
      if (eom) messages_sent++;
   endtask

   task automatic send_text(input string msg);
      for (int i = 0; i < msg.len(); i++) begin
         send_byte(msg[i], i == msg.len() - 1);
      end
   endtask

   // result side: check every transaction, then pick the next ready state
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_symbols.size() == 0) begin
               report_mismatch("unexpected symbol", int'(rsp_tdata), 0);
            end else begin
               b32e_pkg::sym_type want;
               want = expected_symbols.pop_front();
               if (rsp_tdata[6:0] != want.symbol_char)
                  report_mismatch("symbol_char", int'(rsp_tdata[6:0]),
                                  int'(want.symbol_char));
               if (rsp_tdata[7] != 1'b0)
                  report_mismatch("tdata pad bit", int'(rsp_tdata[7]), 0);
               if (rsp_tlast != want.last_symbol)
                  report_mismatch("last_symbol", int'(rsp_tlast), int'(want.last_symbol));
            end
            symbols_seen++;
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            rsp_stall = pick_gap();
         end
      end
   end

   // one-byte messages always give a data symbol plus a filled closing one
   task automatic test_single_byte_messages();
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h80, 1'b1);
      send_byte(8'h01, 1'b1);
   endtask

   // rfc 4648 test strings, covering every leftover count at message end
   task automatic test_rfc_vectors();
      send_text("f");
      send_text("fo");
      send_text("foo");
      send_text("foob");
      send_text("fooba");
   endtask

   // 40 bits end exactly on a group: the last data symbol carries the flag
   task automatic test_group_boundary();
      for (int i = 0; i < 5; i++) send_byte(8'hFF, i == 4);
   endtask

   task automatic test_random_messages();
      int start;
      int len;
      int r;
      logic [7:0] value;
      start = bytes_sent;
      while (bytes_sent - start < RandBytes) begin
         // some messages run with no idling on either side
         no_idle = ($urandom_range(0, 4) == 0);
         len = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 8) : $urandom_range(9, 30);
         for (int i = 0; i < len; i++) begin
            r = $urandom_range(0, 19);
            if (r == 0) value = 8'h00;
            else if (r == 1) value = 8'hFF;
            else value = 8'($urandom_range(0, 255));
            send_byte(value, i == len - 1);
         end
      end
      no_idle = 1'b0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_single_byte_messages();
      test_rfc_vectors();
      test_group_boundary();
      test_random_messages();

      req_tvalid <= 1'b0;
      while (expected_symbols.size() != 0) @(posedge clock);
      repeat (TailWait) @(posedge clock);
      if (expected_symbols.size() != 0)
         report_mismatch("symbols never delivered", 0, expected_symbols.size());

      $display("encoded %0d bytes in %0d messages, %0d symbols checked",
               bytes_sent, messages_sent, symbols_seen);
      $display("directed rfc strings, one-byte and group-boundary endings, then random messages");
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("timeout waiting on the encoder");
      $display("*** FAILED ***");
      $finish;
   end

endmodule
`default_nettype wire

[sim.f]
rtl/b32e_pkg.sv
rtl/b32e_slicer.sv
rtl/base32_encoder.sv
bench/base32_encoder_tb.sv
